FILE: src/b64e_pkg.sv
// Shared beat and group types for the Base64 encoder.
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       final_char;
  } char_beat_t;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  pad_count;
    logic        last;
  } group_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

endpackage

FILE: src/b64e_front.sv
// Byte gatherer: collects bytes into three-byte groups and hands each closed group on.
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_beat_t byte_beat,
  output logic       push_valid,
  input  logic       push_ready,
  output group_t     push_group
);

  logic [1:0]  group_position;
  logic [15:0] pending_bytes;
  logic        accept;

  assign byte_ready = push_ready;
  assign accept     = byte_valid && push_ready;

  always_comb begin
    push_valid = 1'b0;
    push_group = '0;
    unique case (group_position)
      2'd0: begin
        push_valid           = byte_valid && byte_beat.end_of_message;
        push_group.word      = {byte_beat.data_byte, 16'h0000};
        push_group.pad_count = 2'd2;
        push_group.last      = 1'b1;
      end
      2'd1: begin
        push_valid           = byte_valid && byte_beat.end_of_message;
        push_group.word      = {pending_bytes[15:8], byte_beat.data_byte, 8'h00};
        push_group.pad_count = 2'd1;
        push_group.last      = 1'b1;
      end
      default: begin
        push_valid           = byte_valid;
        push_group.word      = {pending_bytes, byte_beat.data_byte};
        push_group.pad_count = 2'd0;
        push_group.last      = byte_beat.end_of_message;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
    end else if (accept) begin
      if (byte_beat.end_of_message || group_position >= 2'd2) begin
        group_position <= 2'd0;
      end else begin
        group_position <= group_position + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !byte_beat.end_of_message) begin
      if (group_position == 2'd0) begin
        pending_bytes[15:8] <= byte_beat.data_byte;
      end else if (group_position == 2'd1) begin
        pending_bytes[7:0] <= byte_beat.data_byte;
      end
    end
  end

endmodule

FILE: src/b64e_queue.sv
// Short group queue between the byte gatherer and the character serializer.
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  group_t push_group,
  output logic   pop_valid,
  input  logic   pop_ready,
  output group_t pop_group
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_group  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

endmodule

FILE: src/b64e_back.sv
// Character serializer: turns each queued group into four Base64 characters.
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  group_t     pop_group,
  output logic       char_valid,
  input  logic       char_ready,
  output char_beat_t char_beat
);

  group_t     cur;
  logic [1:0] idx;
  logic       active;
  logic       advance;
  logic       load;
  logic [5:0] sext;
  logic       is_pad;
  char_beat_t next_beat;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  assign advance   = active && (!char_valid || char_ready);
  assign load      = pop_valid && (!active || (advance && idx == 2'd3));
  assign pop_ready = !active || (advance && idx == 2'd3);

  always_comb begin
    unique case (idx)
      2'd0:    sext = cur.word[23:18];
      2'd1:    sext = cur.word[17:12];
      2'd2:    sext = cur.word[11:6];
      default: sext = cur.word[5:0];
    endcase
    is_pad = ((idx == 2'd3) && (cur.pad_count != 2'd0)) ||
             ((idx == 2'd2) && (cur.pad_count == 2'd2));
    next_beat.out_char   = is_pad ? PAD_CHAR : b64_char(sext);
    next_beat.final_char = cur.last && (idx == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
        idx    <= 2'd0;
      end else if (advance) begin
        if (idx == 2'd3) begin
          active <= 1'b0;
        end
        idx <= idx + 2'd1;
      end
      if (advance) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_group;
    end
    if (advance) begin
      char_beat <= next_beat;
    end
  end

`ifndef SYNTH
  a_keep_streaming: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && active) |=> char_valid)
    else $error("serializer dropped a character while a group was active");

  a_final_closes_group: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_beat.final_char) |-> (!active || idx == 2'd0))
    else $error("final character shown while a group is half sent");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_ready) |=> $stable(idx))
    else $error("character index moved while the output was stalled");
`endif

endmodule

FILE: src/base64_encoder_unit.sv
// Top level of the streaming Base64 encoder.
//
//   channel  direction  handshake                 beat
//   byte     in         byte_valid / byte_ready   byte_beat (data_byte, end_of_message)
//   char     out        char_valid / char_ready   char_beat (out_char, final_char)
//
// A byte is taken every cycle while the group queue has room.
// The character port issues one character per cycle while char_ready is high and groups are queued; a group gives four.
// A closing byte passes through a queue slot, the serializer's group register and its character register first.
// Reset is synchronous and leaves the queue empty and no bytes pending.
// Either side may stall on its own; the queue absorbs QUEUE_DEPTH groups.
module base64_encoder_unit
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_beat_t byte_beat,
  output logic       char_valid,
  input  logic       char_ready,
  output char_beat_t char_beat
);

  logic   push_valid;
  logic   push_ready;
  group_t push_group;
  logic   pop_valid;
  logic   pop_ready;
  group_t pop_group;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_group (push_group)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_group (push_group),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_group  (pop_group)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_group  (pop_group),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_beat  (char_beat)
  );

endmodule
